// ===== hw/rtl/mm4_pkg.sv =====
// Shared types and constants for the 4x4 matrix multiplier.
// No dependencies; the controller, datapath, top level and product checker use it by scoped names.
`timescale 1ns / 1ps

package mm4_pkg;

    // Fraction bits of the fixed-point format
    localparam int FRAC_BITS = 16;

    // Result queue in the datapath, and the credit count that guards it
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CR_W       = 3;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // write the incoming pair into the stores
        logic issue;      // read one pair of operands for a multiply-accumulate
        logic first;      // first term of a product element
        logic last_k;     // final term of a product element
        logic last_elem;  // final element of the product matrix
    } cmd_t;

    // Control that travels beside the operands through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
        logic last_elem;
    } pipe_t;

endpackage

// ===== hw/rtl/mm4_ctrl.sv =====
// Controller of the matrix multiplier: load sequencing, MAC issue order and
// result-queue credits. Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_ctrl #(
    parameter int DIM     = 4,
    parameter int CELLS   = DIM * DIM,
    parameter int CELL_AW = $clog2(CELLS),
    parameter int IDX_W   = $clog2(DIM)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_pop,
    output mm4_pkg::cmd_t       cmd,
    output logic [CELL_AW-1:0]  wr_addr,
    output logic [CELL_AW-1:0]  left_addr,
    output logic [CELL_AW-1:0]  right_addr
);

    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(DIM - 1);
    localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] DIM_A     = CELL_AW'(DIM);

    mm4_pkg::state_t           state_reg, state_next;
    logic [CELL_AW-1:0]        load_pos_reg, load_pos_next;
    logic [IDX_W-1:0]          row_reg, row_next;
    logic [IDX_W-1:0]          col_reg, col_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic [mm4_pkg::CR_W-1:0]  credit_reg, credit_next;
    logic                      issue;
    logic                      first;
    logic                      last_k;
    logic                      last_elem;
    logic                      start;

    assign first     = (k_reg == '0);
    assign last_k    = (k_reg == IDX_LAST);
    assign last_elem = last_k && (row_reg == IDX_LAST) && (col_reg == IDX_LAST);
    // Start a new element only with a free slot in the result queue
    assign issue     = (state_reg == mm4_pkg::ST_RUN) &&
                       (!first || (credit_reg != '0));
    assign start     = issue && first;

    assign in_ready  = (state_reg == mm4_pkg::ST_LOAD);
    assign wr_addr   = load_pos_reg;
    assign left_addr  = CELL_AW'(row_reg) * DIM_A + CELL_AW'(k_reg);
    assign right_addr = CELL_AW'(k_reg) * DIM_A + CELL_AW'(col_reg);

    assign cmd.load      = in_valid && in_ready;
    assign cmd.issue     = issue;
    assign cmd.first     = first;
    assign cmd.last_k    = last_k;
    assign cmd.last_elem = last_elem;

    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        unique case (state_reg)
            mm4_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (load_pos_reg == CELL_LAST)
                    begin
                        load_pos_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                        k_next        = '0;
                        state_next    = mm4_pkg::ST_RUN;
                    end
                    else
                    begin
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                end
            end
            mm4_pkg::ST_RUN:
            begin
                if (issue)
                begin
                    if (!last_k)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        k_next = '0;
                        if (col_reg == IDX_LAST)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        // Reads are done; new loads may overwrite the stores
                        if (last_elem)
                        begin
                            state_next = mm4_pkg::ST_LOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = mm4_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        credit_next = credit_reg;
        if (start && !out_pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
        else if (!start && out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mm4_pkg::ST_LOAD;
            load_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
            credit_reg   <= mm4_pkg::CR_W'(mm4_pkg::FIFO_DEPTH);
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
            credit_reg   <= credit_next;
        end
    end

endmodule

// ===== hw/rtl/mm4_datapath.sv =====
// Datapath of the matrix multiplier: operand stores, pipelined split
// multiplier, accumulator, round/saturate and result queue. Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_datapath #(
    parameter int DIM         = 4,
    parameter int VALUE_WIDTH = 32,
    parameter int CELLS       = DIM * DIM,
    parameter int CELL_AW     = $clog2(CELLS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mm4_pkg::cmd_t           cmd,
    input  logic [CELL_AW-1:0]      wr_addr,
    input  logic [CELL_AW-1:0]      left_addr,
    input  logic [CELL_AW-1:0]      right_addr,
    input  logic [VALUE_WIDTH-1:0]  left_in,
    input  logic [VALUE_WIDTH-1:0]  right_in,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [VALUE_WIDTH-1:0]  out_data,
    output logic                    out_sat,
    output logic                    out_last,
    output logic                    out_pop
);

    localparam int W      = VALUE_WIDTH;
    localparam int LO_W   = W / 2;
    localparam int HI_W   = W - LO_W;
    localparam int PL_W   = W + LO_W + 1;
    localparam int PH_W   = W + HI_W;
    localparam int PROD_W = 2 * W;
    localparam int ACC_W  = 2 * W + $clog2(DIM) + 1;
    localparam int SH_W   = ACC_W - mm4_pkg::FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_LSB =
        ACC_W'(1) <<< (mm4_pkg::FRAC_BITS - 1);
    localparam logic [W-1:0] MAX_V = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W - 1){1'b0}}};

    // Operand stores
    logic [W-1:0] left_mem  [CELLS];
    logic [W-1:0] right_mem [CELLS];

    // Pipeline
    mm4_pkg::pipe_t            s1_reg, s2_reg, s3_reg;
    logic signed [W-1:0]       a_reg, b_reg;
    logic signed [HI_W-1:0]    b_hi;
    logic signed [LO_W:0]      b_lo;
    logic signed [PH_W-1:0]    p_hi_reg;
    logic signed [PL_W-1:0]    p_lo_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      done_valid_reg, done_last_reg;
    logic signed [ACC_W-1:0]   rnd_reg;
    logic                      rnd_valid_reg, rnd_last_reg;
    logic [SH_W-1:0]           shifted;
    logic [SH_W-W:0]           top_bits;
    logic                      in_range;
    logic [W-1:0]              sat_value;
    logic                      sat_flag;

    // Result queue
    logic [W-1:0]                 fifo_data [mm4_pkg::FIFO_DEPTH];
    logic                         fifo_sat  [mm4_pkg::FIFO_DEPTH];
    logic                         fifo_last [mm4_pkg::FIFO_DEPTH];
    logic [mm4_pkg::FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [mm4_pkg::CR_W-1:0]     count_reg, count_next;
    logic                         push;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_mem[wr_addr]  <= left_in;
            right_mem[wr_addr] <= right_in;
        end
        if (cmd.issue)
        begin
            a_reg <= left_mem[left_addr];
            b_reg <= right_mem[right_addr];
        end
    end

    // Split the right operand: signed high half, unsigned low half
    assign b_hi = b_reg[W-1:LO_W];
    assign b_lo = {1'b0, b_reg[LO_W-1:0]};

    assign prod_next = (PROD_W'(p_hi_reg) <<< LO_W) + PROD_W'(p_lo_reg);
    assign acc_next  = s3_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        p_hi_reg <= PH_W'(a_reg) * PH_W'(b_hi);
        p_lo_reg <= PL_W'(a_reg) * PL_W'(b_lo);
        prod_reg <= prod_next;
        if (s3_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        rnd_reg       <= acc_reg + HALF_LSB;
        done_last_reg <= s3_reg.last_elem;
        rnd_last_reg  <= done_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg         <= '0;
            s2_reg         <= '0;
            s3_reg         <= '0;
            done_valid_reg <= 1'b0;
            rnd_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_reg         <= '{cmd.issue, cmd.first, cmd.last_k, cmd.last_elem};
            s2_reg         <= s1_reg;
            s3_reg         <= s2_reg;
            done_valid_reg <= s3_reg.valid && s3_reg.last_k;
            rnd_valid_reg  <= done_valid_reg;
        end
    end

    // Drop the fraction bits, then clip to the signed output range
    assign shifted   = rnd_reg[ACC_W-1:mm4_pkg::FRAC_BITS];
    assign top_bits  = shifted[SH_W-1:W-1];
    assign in_range  = (&top_bits) || !(|top_bits);
    assign sat_flag  = !in_range;
    assign sat_value = in_range ? shifted[W-1:0] :
                       (shifted[SH_W-1] ? MIN_V : MAX_V);

    assign push      = rnd_valid_reg;
    assign out_valid = (count_reg != '0);
    assign out_pop   = out_valid && out_ready;
    assign out_data  = fifo_data[rd_ptr_reg];
    assign out_sat   = fifo_sat[rd_ptr_reg];
    assign out_last  = fifo_last[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !out_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && out_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_data[wr_ptr_reg] <= sat_value;
            fifo_sat[wr_ptr_reg]  <= sat_flag;
            fifo_last[wr_ptr_reg] <= rnd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// Top level of the fixed-point matrix multiplier.
// Instantiates mm4_ctrl and mm4_datapath; depends on mm4_pkg.
`timescale 1ns / 1ps

// Usage
//  Slave stream (s_axis_*): one transaction per matrix position, row-major.
//  Each carries an element of the left matrix A and the element of the right
//  matrix B at the same position, signed fixed point with 16 fraction bits.
//  After DIM*DIM transactions the block computes C = A*B and sends the
//  DIM*DIM elements of C on the master stream (m_axis_*) in row-major order.
//  Each element is rounded to nearest (ties toward plus infinity) and clipped
//  to the signed range; tuser marks a clipped element, tlast the final one.
// Timing
//  While loading, s_axis_tready stays high, so no transaction is held off.
//  The product runs on one pipelined multiply-accumulate unit, one term per
//  cycle unless it holds for a free slot in the result queue; s_axis_tready
//  is low meanwhile. Each term passes the operand, partial-product, product
//  and accumulator registers; a finished element then passes the round
//  register into the result queue. Loading of the next run may start as
//  soon as all terms are issued, while results still drain.
// Reset and stall
//  rst_n clears the load position, the sequencer and the result queue.
//  A stalled receiver fills a four-entry result queue; the sequencer then
//  holds before starting the next element, so no result is lost.

module matrix_multiply_4x4 #(
    parameter int DIM         = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: left_element, right_element (lowest bits first), zero padded
    input  logic [((2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: product_element, zero padded
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0]     m_axis_tdata,
    // tuser: saturated
    output logic                                   m_axis_tuser,
    // tlast: last_of_run
    output logic                                   m_axis_tlast
);

    localparam int CELLS   = DIM * DIM;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int OUT_TW  = ((VALUE_WIDTH + 7) / 8) * 8;

    mm4_pkg::cmd_t             cmd;
    logic [CELL_AW-1:0]        wr_addr;
    logic [CELL_AW-1:0]        left_addr;
    logic [CELL_AW-1:0]        right_addr;
    logic                      out_pop;
    logic [VALUE_WIDTH-1:0]    product_element;

    mm4_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .out_pop    (out_pop),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .left_addr  (left_addr),
        .right_addr (right_addr)
    );

    mm4_datapath #(
        .DIM         (DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .left_addr  (left_addr),
        .right_addr (right_addr),
        .left_in    (s_axis_tdata[VALUE_WIDTH-1:0]),
        .right_in   (s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (product_element),
        .out_sat    (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .out_pop    (out_pop)
    );

    // Pad the result to whole bytes
    assign m_axis_tdata = OUT_TW'(product_element);

endmodule

// ===== hw/rtl/mm4_checker.sv =====
// Port-level checker for the matrix multiplier, bound to the top level.
// Depends on matrix_multiply_4x4 ports only.
`timescale 1ns / 1ps

module mm4_checker #(
    parameter int DIM         = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    input  logic                                         s_axis_tready,
    input  logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0]     m_axis_tdata,
    input  logic                                         m_axis_tuser,
    input  logic                                         m_axis_tlast
);

    localparam int CELLS = DIM * DIM;
    localparam int CNT_W = $clog2(CELLS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELLS - 1);

    logic [CNT_W-1:0] in_cnt_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                in_cnt_reg <= (in_cnt_reg == CNT_LAST) ? '0 : in_cnt_reg + 1'b1;
            end
            if (out_acc)
            begin
                out_cnt_reg <= (out_cnt_reg == CNT_LAST) ? '0 : out_cnt_reg + 1'b1;
            end
        end
    end

    // A result held by the receiver stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // The transaction that completes the matrices closes the input side
    a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_cnt_reg == CNT_LAST) |=> !s_axis_tready)
        else $error("input still open after a full matrix");

    // tlast marks exactly the final element of each product matrix
    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (m_axis_tlast == (out_cnt_reg == CNT_LAST)))
        else $error("tlast out of place");

endmodule

bind matrix_multiply_4x4 mm4_checker #(
    .DIM         (DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mm4_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/mm4_product_checker.sv =====
// Checker for the 4x4 fixed-point matrix multiplier: watches both streams,
// predicts every product element and compares it with what the block sends.
// Depends on mm4_pkg for the fraction width; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module mm4_product_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          products_checked,
    output int          clipped_seen
);

    localparam int DIM   = 4;
    localparam int CELLS = DIM * DIM;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [67:0] HALF_LSB = 68'sd1 <<< (mm4_pkg::FRAC_BITS - 1);
    localparam logic signed [67:0] Q_MAX    = 68'sd2147483647;
    localparam logic signed [67:0] Q_MIN    = -68'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic        clipped;
        logic        last;
    } product_t;

    product_t    expected_products[$];
    product_t    want;
    logic [31:0] left_matrix  [CELLS];
    logic [31:0] right_matrix [CELLS];
    int          load_index;

    // Exact dot product of row and column, one rounding, then clip to 32 bits.
    function automatic product_t dot_product(int row, int col);
        logic signed [67:0] sum;
        logic signed [67:0] lhs;
        logic signed [67:0] rhs;
        logic signed [67:0] rounded;
        product_t           res;
        sum = '0;
        for (int k = 0; k < DIM; k++)
        begin
            lhs = $signed(left_matrix[row * DIM + k]);
            rhs = $signed(right_matrix[k * DIM + col]);
            sum = sum + lhs * rhs;
        end
        // adding half an LSB before the floor shift rounds ties upward
        rounded = (sum + HALF_LSB) >>> mm4_pkg::FRAC_BITS;
        res.clipped = 1'b1;
        if (rounded > Q_MAX)
            res.value = 32'h7FFF_FFFF;
        else if (rounded < Q_MIN)
            res.value = 32'h8000_0000;
        else
        begin
            res.value   = rounded[31:0];
            res.clipped = 1'b0;
        end
        res.last = (row == DIM - 1) && (col == DIM - 1);
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatches       = 0;
            pending          = 0;
            products_checked = 0;
            clipped_seen     = 0;
            load_index       = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_products.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] unexpected product: data=%h sat=%b last=%b",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = expected_products.pop_front();
                    products_checked++;
                    if (want.clipped)
                        clipped_seen++;
                    if (m_tdata !== want.value || m_tuser !== want.clipped
                        || m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("[%0t] mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     $realtime, want.value, want.clipped, want.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                left_matrix[load_index]  = s_tdata[31:0];
                right_matrix[load_index] = s_tdata[63:32];
                if (load_index == CELLS - 1)
                begin
                    load_index = 0;
                    for (int i = 0; i < DIM; i++)
                        for (int j = 0; j < DIM; j++)
                            expected_products.push_back(dot_product(i, j));
                end
                else
                    load_index++;
            end

            pending = expected_products.size();
        end
    end

endmodule

// ===== tb/matrix_multiply_4x4_tb.sv =====
// Testbench top for the 4x4 fixed-point matrix multiplier: drives element
// pairs, throttles the result stream and gives the verdict.
// Depends on matrix_multiply_4x4 (and mm4_pkg) and on mm4_product_checker.
`timescale 1ns / 1ps

module matrix_multiply_4x4_tb;

    localparam int DIM             = 4;
    localparam int CELLS           = DIM * DIM;
    localparam int RANDOM_MATRICES = 20;    // 320 random transactions after the directed set
    localparam int STALL_LIMIT     = 5000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES    = 20;    // extra wait once nothing is pending, to catch a stray result

    // How the elements of one random matrix pair are drawn
    typedef enum int {
        FILL_NOISE,       // any 32-bit pattern, mostly clipped sums
        FILL_HALF_STEPS,  // products land on half an LSB: rounding ties of both signs
        FILL_MODERATE,    // small magnitudes, sums stay in range
        FILL_NEAR_LIMIT,  // sums straddle the clipping boundary
        FILL_EXTREMES     // min, max, zero, +-1.0, +-1 LSB mixed with noise
    } fill_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // left_element [31:0], right_element [63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // product_element [31:0]
    logic        m_tuser;   // saturated
    logic        m_tlast;   // last_of_run

    int mismatches;
    int pending;
    int products_checked;
    int clipped_seen;
    int items_sent = 0;
    int idle_cycles = 0;

    matrix_multiply_4x4 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    mm4_product_checker u_product_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .mismatches       (mismatches),
        .pending          (pending),
        .products_checked (products_checked),
        .clipped_seen     (clipped_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop the run if the streams freeze: count cycles in which neither
    // side completes a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles, %0d products pending",
                         STALL_LIMIT, pending);
                $display("matrix_multiply_4x4_tb failed");
                $finish;
            end
        end
    end

    // Directed matrix pair. Rows 0 and 1 of A are all min and all max, and
    // columns 0 and 1 of B likewise, so the top-left 2x2 block of C clips
    // both ways. Row 2 of A times row 0 of B gives exactly +0.5 and -0.5
    // LSB, the two rounding ties. Row 3 of A mixes zero, +-1.0 and one LSB.
    function automatic logic [31:0] directed_element(int pos, bit is_left);
        int row;
        int col;
        row = pos / DIM;
        col = pos % DIM;
        if (is_left)
        begin
            case (row)
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return (col == 0) ? 32'h0000_0100 : 32'h0000_0000;
                default:
                    case (col)
                        0: return 32'h0000_0000;
                        1: return 32'h0001_0000;
                        2: return 32'hFFFF_0000;
                        default: return 32'h0000_0001;
                    endcase
            endcase
        end
        case (col)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2:
                case (row)
                    0: return 32'h0000_0080;
                    1: return 32'h0001_8000;
                    2: return 32'h1234_5678;
                    default: return 32'h7FFF_0001;
                endcase
            default:
                case (row)
                    0: return 32'hFFFF_FF80;
                    1: return 32'hFFFE_8000;
                    2: return 32'hEDCB_A988;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    function automatic logic [31:0] pick_element(fill_mode_t mode, bit is_left);
        logic [31:0] r;
        int          steps;
        r = $urandom;
        case (mode)
            FILL_NOISE:
                return r;
            FILL_HALF_STEPS:
            begin
                // left is m/256, right n/512: every product is a multiple of half an LSB
                steps = $urandom_range(0, 127) - 64;
                return is_left ? 32'(steps * 256) : 32'(steps * 128);
            end
            FILL_MODERATE:
                return {{11{r[20]}}, r[20:0]};
            FILL_NEAR_LIMIT:
                return {{8{r[23]}}, r[23:0]};
            default:
                case ($urandom_range(0, 7))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h0001_0000;
                    4: return 32'hFFFF_0000;
                    5: return 32'h0000_0001;
                    6: return 32'hFFFF_FFFF;
                    default: return r;
                endcase
        endcase
    endfunction

    // Gap after a transaction: mostly none or short, now and then long.
    function automatic int pick_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one element pair at a falling edge, hold it until accepted,
    // then idle for a random gap. Returns at a falling edge.
    task automatic send_pair(logic [31:0] left, logic [31:0] right, bit burst);
        int gap;
        s_tdata  <= {right, left};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        gap = pick_gap(burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off the sender until every predicted product has come out.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Result side: ready stretches, mostly short with some long ones,
    // broken up by stalls that are mostly short and sometimes long enough
    // to fill the block's result queue.
    initial
    begin : result_throttle
        int run_len;
        int stall_len;
        int r;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            run_len = (r < 85) ? $urandom_range(1, 20) : $urandom_range(100, 300);
            m_tready <= 1'b1;
            repeat (run_len) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 70)
                stall_len = $urandom_range(1, 3);
            else if (r < 92)
                stall_len = $urandom_range(4, 12);
            else
                stall_len = $urandom_range(20, 80);
            m_tready <= 1'b0;
            repeat (stall_len) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        fill_mode_t mode;
        bit         burst;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pair of matrices, then let every product drain.
        for (int p = 0; p < CELLS; p++)
            send_pair(directed_element(p, 1'b1), directed_element(p, 1'b0), 1'b0);
        hold_until_drained();

        // Random matrices: walk through every fill mode once, then pick freely.
        // About a quarter of them load back to back with no gaps.
        for (int m = 0; m < RANDOM_MATRICES; m++)
        begin
            mode  = (m < 5) ? fill_mode_t'(m) : fill_mode_t'($urandom_range(0, 4));
            burst = ($urandom_range(0, 3) == 0);
            for (int p = 0; p < CELLS; p++)
            begin
                send_pair(pick_element(mode, 1'b1), pick_element(mode, 1'b0), burst);
                // pause with seven pairs of the matrix loaded and the previous run draining
                if (m == 9 && p == 6)
                    hold_until_drained();
            end
            if (m == 14)
                hold_until_drained();
        end

        // Drop valid, wait out the outstanding products and a little more
        // so a stray extra result would still be caught.
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d element pairs (%0d matrix products); checked %0d product elements,",
                 items_sent, items_sent / CELLS, products_checked);
        $display("%0d of them clipped; %0d mismatches.", clipped_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("matrix_multiply_4x4_tb passed");
        else
            $display("matrix_multiply_4x4_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_ctrl.sv
hw/rtl/mm4_datapath.sv
hw/rtl/matrix_multiply_4x4.sv
hw/rtl/mm4_checker.sv
tb/mm4_product_checker.sv
tb/matrix_multiply_4x4_tb.sv
